[rtl/cobs_frame_encoder_defines.svh]
// Assertion macros used by the COBS frame encoder RTL.
`ifndef COBS_FRAME_ENCODER_DEFINES_SVH
`define COBS_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cfe_pkg.sv]
// Types and constants of the COBS frame encoder.
package cfe_pkg;

  localparam int POS_W       = 13;
  localparam int BYTE_W      = 8;
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] CODE_FIRST = 8'h01;
  localparam logic [BYTE_W-1:0] CODE_FULL  = 8'hFF;
  localparam logic [BYTE_W-1:0] CODE_ZERO  = 8'h00;
  localparam logic [POS_W-1:0]  POS_START  = 13'h0001;
  localparam logic [POS_W-1:0]  SLOT_START = 13'h0000;
  localparam logic [POS_W-1:0]  POS_ONE    = 13'h0001;

  // One buffer write.
  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] value;
    logic              frame_end;
  } cfe_res_t;

  // All writes caused by one input byte, oldest in res[0].
  typedef struct packed {
    logic [1:0]              count_m1;
    logic                    overflow;
    cfe_res_t [MAX_RES-1:0]  res;
  } cfe_rec_t;

endpackage

[rtl/cobs_frame_encoder.sv]
// Top level of the COBS frame encoder: front end, record queue, back end.
//
//  channel  | ports                                   | beat taken when
//  ---------+-----------------------------------------+-------------------
//  input    | in_data_byte, in_last_byte              | in_push & !in_full
//  result   | out_position, out_value, out_frame_end, | out_pop & !out_empty
//           | out_item_done, out_overflow             |
//  config   | cfg_data (delimiter)                    | cfg_we
//
// Input takes one byte per cycle while the four-record queue has room.
// Each byte yields zero to three buffer writes; the back end sends one result
// beat per cycle while results are popped, so a byte with k writes gives k beats.
// A byte's first result is registered in the queue and then in the output register.
// Synchronous active-low reset returns to frame start with delimiter 0x00.
// A stalled result side fills the queue and then raises in_full.
`include "cobs_frame_encoder_defines.svh"

module cobs_frame_encoder #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [12:0] out_position,
  output logic [7:0]  out_value,
  output logic        out_frame_end,
  output logic        out_item_done,
  output logic        out_overflow
);
  import cfe_pkg::*;

  logic     accept;
  logic     rec_push;
  cfe_rec_t rec;
  cfe_rec_t q_rec;
  logic     q_empty;
  logic     q_pop;

  // Take a beat only when the queue can hold its record.
  assign accept = in_push && !in_full;

  // Classify the byte and advance frame state.
  cfe_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  // Decouple the byte side from the write side.
  cfe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_push),
    .wr_rec (rec),
    .rd_en  (q_pop),
    .rd_rec (q_rec),
    .full   (in_full),
    .empty  (q_empty)
  );

  // Expand records into result beats.
  cfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_rec         (q_rec),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_position  (out_position),
    .out_value     (out_value),
    .out_frame_end (out_frame_end),
    .out_item_done (out_item_done),
    .out_overflow  (out_overflow)
  );

  // Never write a full queue, never read an empty one.
  `CFE_ASSERT_NOW(a_no_push_full, clk, rst_n, rec_push, !in_full, "record pushed into full queue")
  `CFE_ASSERT_NOW(a_no_pop_empty, clk, rst_n, q_pop, !q_empty, "record popped from empty queue")
  // The closing delimiter write is always the last write of its byte.
  `CFE_ASSERT_NOW(a_end_is_done, clk, rst_n, !out_empty && out_frame_end, out_item_done,
    "frame end beat without item done")
  // A record never holds more writes than a byte can cause.
  `CFE_ASSERT_NOW(a_rec_count, clk, rst_n, !q_empty, q_rec.count_m1 != 2'd3,
    "record write count out of range")

endmodule

[rtl/cfe_front.sv]
// Front end: holds frame state, classifies each byte and builds its write record.
module cfe_front #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                rec_push,
  output cfe_pkg::cfe_rec_t   rec
);
  import cfe_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [BYTE_W-1:0] delim_r;
  logic [BYTE_W-1:0] run_code_r, run_code_nxt;
  logic [POS_W-1:0]  code_slot_r, code_slot_nxt;
  logic [POS_W-1:0]  write_pos_r, write_pos_nxt;
  logic [CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic              lrf_r, lrf_nxt;
  logic              ovf_r, ovf_nxt;

  logic              drop;
  cfe_res_t [3:0]    cand;
  logic [3:0]        cand_v;
  logic [1:0]        n;

  function automatic logic [BYTE_W-1:0] code_value(input logic [BYTE_W-1:0] code,
                                                   input logic [BYTE_W-1:0] dl);
    return (code == dl) ? CODE_ZERO : code;
  endfunction

  always_comb begin
    run_code_nxt  = run_code_r;
    code_slot_nxt = code_slot_r;
    write_pos_nxt = write_pos_r;
    in_cnt_nxt    = in_cnt_r;
    lrf_nxt       = lrf_r;
    cand          = '0;
    cand_v        = '0;
    rec           = '0;
    n             = 2'd0;

    drop    = (in_cnt_r >= CNT_MAX);
    ovf_nxt = ovf_r | drop;

    if (!drop) begin
      in_cnt_nxt = in_cnt_r + CNT_ONE;
      lrf_nxt    = 1'b0;
      if (data_byte == delim_r) begin
        // Close the run: patch its code into the reserved slot.
        cand[0]       = '{code_slot_nxt, code_value(run_code_nxt, delim_r), 1'b0};
        cand_v[0]     = 1'b1;
        code_slot_nxt = write_pos_nxt;
        write_pos_nxt = write_pos_nxt + POS_ONE;
        run_code_nxt  = CODE_FIRST;
      end else begin
        cand[0]       = '{write_pos_nxt, data_byte, 1'b0};
        cand_v[0]     = 1'b1;
        write_pos_nxt = write_pos_nxt + POS_ONE;
        run_code_nxt  = run_code_nxt + 8'd1;
        if (run_code_nxt == CODE_FULL) begin
          cand[1]       = '{code_slot_nxt, code_value(CODE_FULL, delim_r), 1'b0};
          cand_v[1]     = 1'b1;
          code_slot_nxt = write_pos_nxt;
          write_pos_nxt = write_pos_nxt + POS_ONE;
          run_code_nxt  = CODE_FIRST;
          lrf_nxt       = 1'b1;
        end
      end
    end

    rec.overflow = ovf_nxt;

    if (last_byte) begin
      if (!lrf_nxt) begin
        cand[2]       = '{code_slot_nxt, code_value(run_code_nxt, delim_r), 1'b0};
        cand_v[2]     = 1'b1;
        code_slot_nxt = write_pos_nxt;
      end
      cand[3]       = '{code_slot_nxt, delim_r, 1'b1};
      cand_v[3]     = 1'b1;
      // Return to frame start.
      run_code_nxt  = CODE_FIRST;
      code_slot_nxt = SLOT_START;
      write_pos_nxt = POS_START;
      in_cnt_nxt    = '0;
      lrf_nxt       = 1'b0;
      ovf_nxt       = 1'b0;
    end

    // Pack the valid writes in order.
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (n != 2'd3)) begin
        rec.res[n] = cand[i];
        n          = n + 2'd1;
      end
    end
    rec.count_m1 = n - 2'd1;
    rec_push     = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= CODE_ZERO;
      run_code_r  <= CODE_FIRST;
      code_slot_r <= SLOT_START;
      write_pos_r <= POS_START;
      in_cnt_r    <= '0;
      lrf_r       <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        delim_r <= cfg_data;
      end
      if (accept) begin
        run_code_r  <= run_code_nxt;
        code_slot_r <= code_slot_nxt;
        write_pos_r <= write_pos_nxt;
        in_cnt_r    <= in_cnt_nxt;
        lrf_r       <= lrf_nxt;
        ovf_r       <= ovf_nxt;
      end
    end
  end

endmodule

[rtl/cfe_queue.sv]
// Short record queue between front and back ends.
module cfe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  cfe_pkg::cfe_rec_t wr_rec,
  input  logic              rd_en,
  output cfe_pkg::cfe_rec_t rd_rec,
  output logic              full,
  output logic              empty
);
  import cfe_pkg::*;

  cfe_rec_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_rec = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + (QPTR_W+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (QPTR_W+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/cfe_back.sv]
// Back end: walks the head record one write per beat into the output register.
module cfe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cfe_pkg::cfe_rec_t q_rec,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [12:0]       out_position,
  output logic [7:0]        out_value,
  output logic              out_frame_end,
  output logic              out_item_done,
  output logic              out_overflow
);
  import cfe_pkg::*;

  logic [1:0] sel_r;
  logic       out_valid_r;
  cfe_res_t   cur;
  logic       is_last;
  logic       load;

  assign cur       = q_rec.res[sel_r];
  assign is_last   = (sel_r == q_rec.count_m1);
  assign load      = !q_empty && (!out_valid_r || out_pop);
  assign q_pop     = load && is_last;
  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_position  <= cur.position;
      out_value     <= cur.value;
      out_frame_end <= cur.frame_end;
      out_item_done <= is_last;
      out_overflow  <= q_rec.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        sel_r       <= is_last ? 2'd0 : sel_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
